[design/pte_pkg.sv]
// -----------------------------------------------------------------------------
// pte_pkg
// Shared constants for the pedestal threshold estimator: ring size, field
// widths and operation codes.
// -----------------------------------------------------------------------------
`default_nettype none

package pte_pkg;

	localparam int unsigned RING_DEPTH = 64;
	localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W      = IDX_W + 1;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned THR_W      = 17;
	localparam int unsigned PROD_W     = IDX_W + SAMPLE_W;
	localparam int unsigned S_TDATA_W  = 16;
	localparam int unsigned M_TDATA_W  = 24;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_CALC = 1'b1;

endpackage

`default_nettype wire

[design/pedestal_threshold_estimator.sv]
// -----------------------------------------------------------------------------
// pedestal_threshold_estimator
// Pedestal sample ring with an in-memory sort and slope search that yields a
// trigger threshold on request.
// -----------------------------------------------------------------------------
// Usage:
//   Input transfers on s_*: s_tuser selects the operation (0 add sample,
//   1 calculate), s_tdata carries the sample. An add writes the ring;
//   adds stream back to back and produce no output.
//   A calculate produces one output transfer on m_*: m_tdata holds the
//   threshold, m_tuser the found flag.
//   While the ring is not yet full, a calculate returns threshold 0 with
//   found clear. Once full, the ring is copied into a work RAM and bubble
//   sorted there, one entry read per cycle, in RING_DEPTH passes; then
//   come a check state, a slope search that reads, multiplies and compares
//   each inspected entry through the single read port of the work RAM,
//   and a finish state. s_tready is low until the result is loaded.
//   Reset clears the write position and the filled flag; RAM contents are
//   not cleared. A result that the receiver stalls sits in the output
//   register; further adds are still accepted, and a following calculate
//   holds at its end until the register is free.
// -----------------------------------------------------------------------------
`default_nettype none

module pedestal_threshold_estimator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [pte_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] sample
	input  wire logic                            s_tuser,  // [0] opcode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [pte_pkg::M_TDATA_W-1:0]   m_tdata,  // [16:0] threshold, [23:17] zero
	output logic                                 m_tuser   // [0] found
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_CHECK,
		ST_SRCH_RD,
		ST_SRCH_MUL,
		ST_SRCH_CMP,
		ST_FIN,
		ST_DONE
	} state_t;

	localparam int unsigned N     = pte_pkg::RING_DEPTH;
	localparam int unsigned IW    = pte_pkg::IDX_W;
	localparam int unsigned CW    = pte_pkg::CNT_W;
	localparam int unsigned SW    = pte_pkg::SAMPLE_W;
	localparam int unsigned TW    = pte_pkg::THR_W;
	localparam int unsigned PW    = pte_pkg::PROD_W;

	state_t            state_q;
	logic [IW-1:0]     wpos_q;
	logic              filled_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     pass_q;
	logic [CW-1:0]     zcnt_q;
	logic [SW-1:0]     carry_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     best_q;
	logic [SW-1:0]     best_val_q;
	logic [SW-1:0]     cur_q;
	logic              first_q;
	logic              cmp_en_q;
	logic [PW-1:0]     lhs_q;
	logic [PW-1:0]     rhs_q;
	logic [TW-1:0]     res_thr_q;
	logic              res_found_q;
	logic              m_tvalid_q;
	logic [TW-1:0]     m_thr_q;
	logic              m_found_q;

	logic              s_xfer;
	logic              ring_we;
	logic [IW-1:0]     ring_raddr;
	logic [SW-1:0]     ring_rdata;
	logic              work_we;
	logic [IW-1:0]     work_waddr;
	logic [SW-1:0]     work_wdata;
	logic [IW-1:0]     work_raddr;
	logic [SW-1:0]     work_rdata;
	logic [SW-1:0]     sort_data;
	logic [SW-1:0]     lo_val;
	logic [SW-1:0]     hi_val;
	logic              sort_proc;
	logic              sort_tail;
	logic [CW:0]       start_sum;
	logic              out_free;
	logic              out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(pte_pkg::M_TDATA_W - TW){1'b0}}, m_thr_q};
	assign m_tuser  = m_found_q;

	// ring write on add, read during the copy pass
	assign ring_we    = s_xfer && (s_tuser == pte_pkg::OP_ADD);
	assign ring_raddr = cnt_q[IW-1:0];

	pte_ram #(.WIDTH(SW), .DEPTH(N)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wpos_q),
		.wdata (s_tdata[SW-1:0]),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// bubble pass: data of entry cnt-1 arrives while entry cnt is read
	assign sort_data = (pass_q == '0) ? ring_rdata : work_rdata;
	assign lo_val    = (sort_data < carry_q) ? sort_data : carry_q;
	assign hi_val    = (sort_data < carry_q) ? carry_q : sort_data;
	assign sort_proc = (cnt_q >= CW'(1)) && (cnt_q <= CW'(N));
	assign sort_tail = (cnt_q == CW'(N + 1));

	always_comb begin
		work_we    = 1'b0;
		work_waddr = cnt_q[IW-1:0] - IW'(2);
		work_wdata = lo_val;
		work_raddr = cnt_q[IW-1:0];
		if (state_q == ST_SORT) begin
			if (sort_tail) begin
				work_we    = 1'b1;
				work_waddr = IW'(N - 1);
				work_wdata = carry_q;
			end else if (sort_proc && (cnt_q >= CW'(2))) begin
				work_we = 1'b1;
			end
		end else begin
			work_raddr = idx_q;
		end
	end

	pte_ram #(.WIDTH(SW), .DEPTH(N)) u_work_ram (
		.clk   (clk),
		.we    (work_we),
		.waddr (work_waddr),
		.wdata (work_wdata),
		.raddr (work_raddr),
		.rdata (work_rdata)
	);

	// search starts halfway between the first nonzero entry and the end
	assign start_sum = {1'b0, zcnt_q} + (CW + 1)'(N);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wpos_q      <= '0;
			filled_q    <= 1'b0;
			cnt_q       <= '0;
			pass_q      <= '0;
			zcnt_q      <= '0;
			m_tvalid_q  <= 1'b0;
			first_q     <= 1'b0;
			cmp_en_q    <= 1'b0;
		end else begin
			// a new result replaces one that leaves in the same cycle
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ring_we) begin
				if (wpos_q == IW'(N - 1)) begin
					wpos_q   <= '0;
					filled_q <= 1'b1;
				end else begin
					wpos_q <= wpos_q + IW'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer && (s_tuser == pte_pkg::OP_CALC)) begin
						cnt_q  <= '0;
						pass_q <= '0;
						zcnt_q <= '0;
						if (filled_q) begin
							state_q <= ST_SORT;
						end else begin
							res_thr_q   <= '0;
							res_found_q <= 1'b0;
							state_q     <= ST_DONE;
						end
					end
				end
				ST_SORT: begin
					if (sort_proc) begin
						if (cnt_q == CW'(1)) begin
							carry_q <= sort_data;
						end else begin
							carry_q <= hi_val;
						end
						if ((pass_q == '0) && (sort_data == '0)) begin
							zcnt_q <= zcnt_q + CW'(1);
						end
					end
					if (sort_tail) begin
						cnt_q <= '0;
						if (pass_q == IW'(N - 1)) begin
							state_q <= ST_CHECK;
						end else begin
							pass_q <= pass_q + IW'(1);
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_CHECK: begin
					if (zcnt_q == CW'(N)) begin
						res_thr_q   <= '0;
						res_found_q <= 1'b0;
						state_q     <= ST_DONE;
					end else begin
						idx_q   <= start_sum[IW:1];
						best_q  <= start_sum[IW:1];
						first_q <= 1'b1;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_MUL;
				end
				ST_SRCH_MUL: begin
					cur_q    <= work_rdata;
					cmp_en_q <= !first_q;
					if (first_q) begin
						best_val_q <= work_rdata;
						first_q    <= 1'b0;
					end
					lhs_q   <= PW'(idx_q) * PW'(best_val_q);
					rhs_q   <= PW'(best_q) * PW'(work_rdata);
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					// strict compare keeps the earlier index on ties
					if (cmp_en_q && (lhs_q > rhs_q)) begin
						best_q     <= idx_q;
						best_val_q <= cur_q;
					end
					if (idx_q == IW'(N - 1)) begin
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_SRCH_RD;
					end
				end
				ST_FIN: begin
					res_thr_q   <= TW'(best_val_q) + TW'(best_val_q >> 3);
					res_found_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						m_thr_q    <= res_thr_q;
						m_found_q  <= res_found_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[design/pte_ram.sv]
// -----------------------------------------------------------------------------
// pte_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module pte_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[design/pte_checker.sv]
// -----------------------------------------------------------------------------
// pte_checker
// Port-level checks for the pedestal threshold estimator, bound to the top.
// -----------------------------------------------------------------------------
`default_nettype none

module pte_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [pte_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic                          s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [pte_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic                          m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output changed");

	// no threshold without found
	a_zero_when_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("threshold nonzero with found clear");

	// padding bits above the threshold stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[pte_pkg::M_TDATA_W-1:pte_pkg::THR_W] == '0)
		else $error("output padding not zero");

	// a calculate transfer blocks the input on the next cycle
	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == pte_pkg::OP_CALC) |=> !s_tready)
		else $error("input ready right after calculate");

endmodule

bind pedestal_threshold_estimator pte_checker u_pte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
